/* rtl/brwm_pkg.sv */
package brwm_pkg;

    // Sums are 32 bits wide; a window never holds more than 2^32-1 microseconds.
    localparam int SUM_W = 32;
    // Percentages run from 0 to 100.
    localparam int PCT_W = 7;
    localparam int PCT_SCALE = 100;
    // A busy sum times 100 needs 39 bits.
    localparam int PROD_W = SUM_W + PCT_W;
    // Timestamps wrap modulo 2^31.
    localparam int STAMP_W = 31;
    // A report is due every 128 recorded intervals.
    localparam int REPORT_W = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_SHORT,
        ST_RD_LONG,
        ST_COMMIT,
        ST_DIV_SHORT,
        ST_WAIT_SHORT,
        ST_DIV_LONG,
        ST_WAIT_LONG,
        ST_DONE
    } t_state;

endpackage

/* rtl/busy_ratio_window_monitor_unit.sv */
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_func, i_now_us, i_busy_req
// output    out        o_valid / i_stall    o_short_percent, o_long_percent, o_report_due
//
// A recording beat walks the interval ring (two eviction reads and the write
// back), then the shared divider works out each of the two percentages in
// turn.
// First-stamp and clear beats skip the ring and go straight to the divider.
// One beat is in flight at a time. Reset is synchronous and active low and
// empties the statistics; the ring contents need no clearing.
// A finished result waits in the output register while i_stall is high, and
// the next input beat is already taken and worked on during that time.
module busy_ratio_window_monitor_unit #(
    parameter int HISTORY_DEPTH = 128,
    parameter int SHORT_WINDOW = 16,
    parameter int LONG_WINDOW = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [brwm_pkg::STAMP_W-1:0]    i_now_us,
    input  logic                            i_busy_req,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [brwm_pkg::PCT_W-1:0]      o_short_percent,
    output logic [brwm_pkg::PCT_W-1:0]      o_long_percent,
    output logic                            o_report_due
);

    // Longest interval kept, so that a full window still fits in 32 bits.
    localparam logic [31:0] MaxInterval = 32'hFFFF_FFFF / HISTORY_DEPTH;
    localparam int LenW = $clog2({32'd0, MaxInterval} + 64'd1);
    localparam int EntW = LenW + 1;
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    // Windows longer than the history are cut to the history length.
    localparam int ShortWin = (SHORT_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : SHORT_WINDOW;
    localparam int LongWin = (LONG_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : LONG_WINDOW;

    brwm_pkg::t_state r_state;
    brwm_pkg::t_state n_state;

    // Time base and ring bookkeeping.
    logic                             r_no_stamp;
    logic [brwm_pkg::STAMP_W-1:0]     r_last_us;
    logic [AW-1:0]                    r_wr_slot;
    logic [CW-1:0]                    r_filled;
    logic [brwm_pkg::REPORT_W-1:0]    r_report_cnt;
    logic [brwm_pkg::SUM_W-1:0]       r_short_busy;
    logic [brwm_pkg::SUM_W-1:0]       r_short_total;
    logic [brwm_pkg::SUM_W-1:0]       r_long_busy;
    logic [brwm_pkg::SUM_W-1:0]       r_long_total;

    // The beat in flight.
    logic [LenW-1:0]                  r_len;
    logic                             r_busy;
    logic                             r_due;
    logic [brwm_pkg::PCT_W-1:0]       r_short_q;
    logic [brwm_pkg::PCT_W-1:0]       r_long_q;

    // Output register.
    logic                             r_out_valid;
    logic [brwm_pkg::PCT_W-1:0]       r_out_short;
    logic [brwm_pkg::PCT_W-1:0]       r_out_long;
    logic                             r_out_due;

    logic                             in_take;
    logic                             out_take;
    logic                             out_load;
    logic [brwm_pkg::STAMP_W-1:0]     diff_us;
    logic [LenW-1:0]                  new_len;

    logic [CW:0]                      slot_ext;
    logic [AW-1:0]                    short_idx;
    logic [AW-1:0]                    long_idx;

    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic                             wr_en;
    logic [EntW-1:0]                  rd_data;

    logic                             use_short;
    logic                             evict;
    logic [brwm_pkg::SUM_W-1:0]       ev_total;
    logic [brwm_pkg::SUM_W-1:0]       ev_busy;
    logic [brwm_pkg::SUM_W-1:0]       add_total;
    logic [brwm_pkg::SUM_W-1:0]       add_busy;
    logic [brwm_pkg::SUM_W-1:0]       upd_busy;
    logic [brwm_pkg::SUM_W-1:0]       upd_total;

    logic                             div_start;
    logic [brwm_pkg::SUM_W-1:0]       div_busy;
    logic [brwm_pkg::SUM_W-1:0]       div_total;
    logic                             div_done;
    logic [brwm_pkg::PCT_W-1:0]       div_quot;

    assign in_take  = i_valid && (r_state == brwm_pkg::ST_IDLE);
    assign out_take = r_out_valid && !i_stall;
    assign out_load = (r_state == brwm_pkg::ST_DONE) && (!r_out_valid || !i_stall);

    // Interval since the previous stamp, modulo 2^31, clamped to the legal range.
    assign diff_us = i_now_us - r_last_us;
    always_comb begin
        if (diff_us == '0) begin
            new_len = LenW'(1);
        end else if ({1'b0, diff_us} > MaxInterval) begin
            new_len = LenW'(MaxInterval);
        end else begin
            new_len = LenW'(diff_us);
        end
    end

    // The entry that drops out of each window sits one window length behind the
    // write slot, wrapping around the ring.
    assign slot_ext = (CW + 1)'(r_wr_slot);
    always_comb begin
        if (slot_ext >= (CW + 1)'(ShortWin)) begin
            short_idx = AW'(slot_ext - (CW + 1)'(ShortWin));
        end else begin
            short_idx = AW'(slot_ext + (CW + 1)'(HISTORY_DEPTH - ShortWin));
        end
        if (slot_ext >= (CW + 1)'(LongWin)) begin
            long_idx = AW'(slot_ext - (CW + 1)'(LongWin));
        end else begin
            long_idx = AW'(slot_ext + (CW + 1)'(HISTORY_DEPTH - LongWin));
        end
    end

    // Sequencer: next state and the strobes for the ring and the divider.
    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        rd_addr   = short_idx;
        wr_en     = 1'b0;
        div_start = 1'b0;
        div_busy  = r_short_busy;
        div_total = r_short_total;
        unique case (r_state)
            brwm_pkg::ST_IDLE: begin
                if (in_take) begin
                    if (!i_func && !r_no_stamp) begin
                        n_state = brwm_pkg::ST_RD_SHORT;
                    end else begin
                        n_state = brwm_pkg::ST_DIV_SHORT;
                    end
                end
            end
            brwm_pkg::ST_RD_SHORT: begin
                rd_en   = 1'b1;
                rd_addr = short_idx;
                n_state = brwm_pkg::ST_RD_LONG;
            end
            brwm_pkg::ST_RD_LONG: begin
                rd_en   = 1'b1;
                rd_addr = long_idx;
                n_state = brwm_pkg::ST_COMMIT;
            end
            brwm_pkg::ST_COMMIT: begin
                wr_en   = 1'b1;
                n_state = brwm_pkg::ST_DIV_SHORT;
            end
            brwm_pkg::ST_DIV_SHORT: begin
                div_start = 1'b1;
                n_state   = brwm_pkg::ST_WAIT_SHORT;
            end
            brwm_pkg::ST_WAIT_SHORT: begin
                if (div_done) begin
                    n_state = brwm_pkg::ST_DIV_LONG;
                end
            end
            brwm_pkg::ST_DIV_LONG: begin
                div_start = 1'b1;
                div_busy  = r_long_busy;
                div_total = r_long_total;
                n_state   = brwm_pkg::ST_WAIT_LONG;
            end
            brwm_pkg::ST_WAIT_LONG: begin
                if (div_done) begin
                    n_state = brwm_pkg::ST_DONE;
                end
            end
            brwm_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = brwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = brwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brwm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    brwm_ring #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (EntW),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_slot),
        .i_wr_data ({r_busy, r_len}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Window update: the short window's outgoing entry arrives in ST_RD_LONG,
    // the long window's in ST_COMMIT. Each window drops its oldest
    // interval once it is full and takes in the new one.
    assign use_short = (r_state == brwm_pkg::ST_RD_LONG);
    assign evict = use_short ? (r_filled >= CW'(ShortWin)) : (r_filled >= CW'(LongWin));
    assign ev_total  = evict ? brwm_pkg::SUM_W'(rd_data[LenW-1:0]) : '0;
    assign ev_busy   = rd_data[LenW] ? ev_total : '0;
    assign add_total = brwm_pkg::SUM_W'(r_len);
    assign add_busy  = r_busy ? add_total : '0;
    assign upd_busy  = (use_short ? r_short_busy : r_long_busy) - ev_busy + add_busy;
    assign upd_total = (use_short ? r_short_total : r_long_total) - ev_total + add_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_stamp    <= 1'b1;
            r_wr_slot     <= '0;
            r_filled      <= '0;
            r_report_cnt  <= '0;
            r_short_busy  <= '0;
            r_short_total <= '0;
            r_long_busy   <= '0;
            r_long_total  <= '0;
            r_due         <= 1'b0;
        end else begin
            if (in_take) begin
                r_due <= 1'b0;
                if (i_func) begin
                    // Clear command: back to the state after reset.
                    r_no_stamp    <= 1'b1;
                    r_wr_slot     <= '0;
                    r_filled      <= '0;
                    r_report_cnt  <= '0;
                    r_short_busy  <= '0;
                    r_short_total <= '0;
                    r_long_busy   <= '0;
                    r_long_total  <= '0;
                end else begin
                    r_no_stamp <= 1'b0;
                end
            end
            if (r_state == brwm_pkg::ST_RD_LONG) begin
                r_short_busy  <= upd_busy;
                r_short_total <= upd_total;
            end
            if (r_state == brwm_pkg::ST_COMMIT) begin
                r_long_busy  <= upd_busy;
                r_long_total <= upd_total;
                if (r_wr_slot == AW'(HISTORY_DEPTH - 1)) begin
                    r_wr_slot <= '0;
                end else begin
                    r_wr_slot <= r_wr_slot + AW'(1);
                end
                if (r_filled != CW'(HISTORY_DEPTH)) begin
                    r_filled <= r_filled + CW'(1);
                end
                r_report_cnt <= r_report_cnt + brwm_pkg::REPORT_W'(1);
                r_due        <= (r_report_cnt == '1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_len  <= new_len;
            r_busy <= i_busy_req;
            if (!i_func) begin
                r_last_us <= i_now_us;
            end
        end
        if (r_state == brwm_pkg::ST_WAIT_SHORT && div_done) begin
            r_short_q <= div_quot;
        end
        if (r_state == brwm_pkg::ST_WAIT_LONG && div_done) begin
            r_long_q <= div_quot;
        end
    end

    brwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_busy  (div_busy),
        .i_total (div_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Output register: holds a finished beat until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_short <= r_short_q;
            r_out_long  <= r_long_q;
            r_out_due   <= r_due;
        end
    end

    assign o_stall         = (r_state != brwm_pkg::ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_short_percent = r_out_short;
    assign o_long_percent  = r_out_long;
    assign o_report_due    = r_out_due;

endmodule

/* rtl/brwm_ring.sv */
// Interval history: one write port and one read port, read data registered.
module brwm_ring #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 26,
    parameter int AW = 7
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/brwm_div.sv */
// Percentage unit: busy * 100 / total, restoring division one quotient bit per
// cycle. The busy sum never exceeds the total, so seven quotient bits suffice.
module brwm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [brwm_pkg::SUM_W-1:0]      i_busy,
    input  logic [brwm_pkg::SUM_W-1:0]      i_total,
    output logic                            o_done,
    output logic [brwm_pkg::PCT_W-1:0]      o_quot
);

    logic                              r_run;
    logic                              r_done;
    logic                              r_zero;
    logic [2:0]                        r_cnt;
    logic [brwm_pkg::PROD_W-1:0]       r_num;
    logic [brwm_pkg::SUM_W-1:0]        r_den;
    logic [brwm_pkg::PCT_W-1:0]        r_quot;
    logic [brwm_pkg::PROD_W-1:0]       shifted_den;
    logic                              fits;

    assign shifted_den = brwm_pkg::PROD_W'(r_den) << r_cnt;
    assign fits = (r_num >= shifted_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 3'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= brwm_pkg::PROD_W'(i_busy)
                      * brwm_pkg::PROD_W'(brwm_pkg::PCT_SCALE);
            r_den  <= i_total;
            r_zero <= (i_total == '0);
            r_cnt  <= 3'(brwm_pkg::PCT_W - 1);
            r_quot <= '0;
        end else if (r_run) begin
            if (fits) begin
                r_num         <= r_num - shifted_den;
                r_quot[r_cnt] <= 1'b1;
            end
            r_cnt <= r_cnt - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

/* rtl/brwm_checker.sv */
module brwm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            i_func,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [brwm_pkg::PCT_W-1:0]      o_short_percent,
    input logic [brwm_pkg::PCT_W-1:0]      o_long_percent,
    input logic                            o_report_due
);

    // Only one beat is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an accepted beat");

    // Percentages never exceed 100.
    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_short_percent <= 7'd100 && o_long_percent <= 7'd100))
        else $error("percentage above 100");

    // A result waiting on a stall stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_short_percent)
            && $stable(o_long_percent) && $stable(o_report_due)))
        else $error("stalled result changed");

    // A clear beat still runs both percentage passes, so the input stays
    // stalled while they run.
    a_clear_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_func) |=> o_stall [*19])
        else $error("clear beat finished too early");

endmodule

bind busy_ratio_window_monitor_unit brwm_checker u_brwm_checker (.*);

/* dv/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default sizes; the predictor uses the same ones.
    localparam int HISTORY_DEPTH = 128;
    localparam int SHORT_WINDOW = 16;
    localparam int LONG_WINDOW = 128;

    // A window can never reach further back than the ring holds.
    localparam int SHORT_SPAN = (SHORT_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : SHORT_WINDOW;
    localparam int LONG_SPAN = (LONG_WINDOW > HISTORY_DEPTH) ? HISTORY_DEPTH : LONG_WINDOW;

    // Intervals are clamped so that a full window of them still fits a 32-bit sum.
    localparam bit [brwm_pkg::SUM_W-1:0] MAX_INTERVAL = 32'hFFFF_FFFF / 32'(HISTORY_DEPTH);
    localparam int REPORT_PERIOD = 1 << brwm_pkg::REPORT_W;

    localparam int DIRECTED_N = 14;
    localparam int RANDOM_N = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;

    typedef enum bit {
        CMD_RECORD = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_monitor_cmd;

    typedef struct packed {
        logic [brwm_pkg::PCT_W-1:0] short_pct;
        logic [brwm_pkg::PCT_W-1:0] long_pct;
        logic                       due;
    } t_util_result;

    typedef struct {
        t_monitor_cmd                 cmd;
        bit [brwm_pkg::STAMP_W-1:0]   now;
        bit                           busy;
        bit                           typed;
        t_util_result                 want;
    } t_beat_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_func;
    logic [brwm_pkg::STAMP_W-1:0]   i_now_us;
    logic                           i_busy_req;
    logic                           o_valid;
    logic                           i_stall;
    logic [brwm_pkg::PCT_W-1:0]     o_short_percent;
    logic [brwm_pkg::PCT_W-1:0]     o_long_percent;
    logic                           o_report_due;

    busy_ratio_window_monitor_unit #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SHORT_WINDOW  (SHORT_WINDOW),
        .LONG_WINDOW   (LONG_WINDOW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_now_us        (i_now_us),
        .i_busy_req      (i_busy_req),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_short_percent (o_short_percent),
        .o_long_percent  (o_long_percent),
        .o_report_due    (o_report_due)
    );

    // Predictor state: a private copy of everything the block remembers.
    bit [brwm_pkg::SUM_W-1:0]   last_stamp;
    bit [brwm_pkg::SUM_W-1:0]   ring_len [HISTORY_DEPTH];
    bit                         ring_busy [HISTORY_DEPTH];
    int unsigned                next_slot;
    int unsigned                entries_held;
    bit [brwm_pkg::SUM_W-1:0]   short_busy;
    bit [brwm_pkg::SUM_W-1:0]   short_total;
    bit [brwm_pkg::SUM_W-1:0]   long_busy;
    bit [brwm_pkg::SUM_W-1:0]   long_total;
    int unsigned                report_count;

    // Results the block still owes, oldest first.
    t_util_result     expected_util_q [$];
    int               mismatch_count;
    int               results_seen;
    int unsigned      cycle_count;

    // Set by the sender while both sides run without any idle cycles.
    bit               calm_stretch;

    t_beat_row        directed_rows [DIRECTED_N];

    // Bit 31 of the stored stamp marks that no stamp has been seen yet.
    function automatic void clear_util_model();
        last_stamp = 32'h8000_0000;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            ring_len[k] = '0;
            ring_busy[k] = 1'b0;
        end
        next_slot = 0;
        entries_held = 0;
        short_busy = '0;
        short_total = '0;
        long_busy = '0;
        long_total = '0;
        report_count = 0;
    endfunction

    // Truncated percentage, formed at full width so busy * 100 cannot overflow.
    function automatic bit [brwm_pkg::PCT_W-1:0] percent_of(bit [brwm_pkg::SUM_W-1:0] part,
                                                            bit [brwm_pkg::SUM_W-1:0] whole);
        bit [63:0] ratio;
        if (whole == 0) begin
            return '0;
        end
        ratio = (64'(part) * 64'(brwm_pkg::PCT_SCALE)) / 64'(whole);
        return ratio[brwm_pkg::PCT_W-1:0];
    endfunction

    function automatic t_util_result predict_utilization(t_monitor_cmd cmd,
                                                         bit [brwm_pkg::STAMP_W-1:0] now,
                                                         bit busy);
        t_util_result                res;
        bit [brwm_pkg::STAMP_W-1:0]  gap;
        bit [brwm_pkg::SUM_W-1:0]    len;
        int unsigned                 old_slot;
        res.due = 1'b0;
        if (cmd == CMD_CLEAR) begin
            clear_util_model();
        end else begin
            if (!last_stamp[brwm_pkg::SUM_W-1]) begin
                // Elapsed time wraps modulo 2^31, then is clamped to [1, MAX_INTERVAL].
                gap = now - last_stamp[brwm_pkg::STAMP_W-1:0];
                len = 32'(gap);
                if (len == 0) begin
                    len = 1;
                end else if (len > MAX_INTERVAL) begin
                    len = MAX_INTERVAL;
                end
                // Once a window is full, its oldest interval drops out as the new one enters.
                if (entries_held >= SHORT_SPAN) begin
                    old_slot = (next_slot + HISTORY_DEPTH - SHORT_SPAN) % HISTORY_DEPTH;
                    if (ring_busy[old_slot]) begin
                        short_busy -= ring_len[old_slot];
                    end
                    short_total -= ring_len[old_slot];
                end
                if (busy) begin
                    short_busy += len;
                end
                short_total += len;
                if (entries_held >= LONG_SPAN) begin
                    old_slot = (next_slot + HISTORY_DEPTH - LONG_SPAN) % HISTORY_DEPTH;
                    if (ring_busy[old_slot]) begin
                        long_busy -= ring_len[old_slot];
                    end
                    long_total -= ring_len[old_slot];
                end
                if (busy) begin
                    long_busy += len;
                end
                long_total += len;
                ring_len[next_slot] = len;
                ring_busy[next_slot] = busy;
                next_slot = (next_slot + 1) % HISTORY_DEPTH;
                if (entries_held < HISTORY_DEPTH) begin
                    entries_held++;
                end
                report_count = (report_count + 1) % REPORT_PERIOD;
                if (report_count == 0) begin
                    res.due = 1'b1;
                end
            end
            last_stamp = 32'(now);
        end
        res.short_pct = percent_of(short_busy, short_total);
        res.long_pct = percent_of(long_busy, long_total);
        return res;
    endfunction

    // Offers one beat and returns at the falling edge after it was taken.
    // The task is always entered at a falling edge, so valid gets a single
    // assignment per time step: either it stays high with a new payload, or it
    // drops for a short random gap first.
    task automatic send_beat(t_monitor_cmd cmd, bit [brwm_pkg::STAMP_W-1:0] now, bit busy,
                             bit typed, t_util_result want);
        t_util_result predicted;
        if (!calm_stretch && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= cmd;
        i_now_us <= now;
        i_busy_req <= busy;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        // The predictor runs for every beat so its state tracks the block even
        // where the table already spells out the answer.
        predicted = predict_utilization(cmd, now, busy);
        expected_util_q.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a run that never drains ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result side. Stalls fall at random about 8 percent of the time, none
    // during the calm stretch, and once the receiver holds off for a long
    // stretch so the block fills up and has to stall its own input.
    initial begin : result_stall_driver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (!calm_stretch && $urandom_range(0, 99) < 8) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Every result beat is held against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_util_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_util_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected: short %0d long %0d due %0d",
                         $realtime, o_short_percent, o_long_percent, o_report_due);
            end else begin
                want = expected_util_q.pop_front();
                if (o_short_percent !== want.short_pct) begin
                    mismatch_count++;
                    $display("%0t: short percent expected %0d, got %0d",
                             $realtime, want.short_pct, o_short_percent);
                end
                if (o_long_percent !== want.long_pct) begin
                    mismatch_count++;
                    $display("%0t: long percent expected %0d, got %0d",
                             $realtime, want.long_pct, o_long_percent);
                end
                if (o_report_due !== want.due) begin
                    mismatch_count++;
                    $display("%0t: report due expected %0d, got %0d",
                             $realtime, want.due, o_report_due);
                end
            end
        end
    end

    initial begin : stimulus
        bit [brwm_pkg::STAMP_W-1:0]  stamp_cursor;
        bit [brwm_pkg::SUM_W-1:0]    step;
        t_monitor_cmd                cmd;
        bit [brwm_pkg::STAMP_W-1:0]  now;
        int unsigned                 pick;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = 1'b0;
        i_now_us = '0;
        i_busy_req = 1'b0;
        i_stall = 1'b0;
        mismatch_count = 0;
        results_seen = 0;
        calm_stretch = 1'b0;
        clear_util_model();

        // Directed beats. The typed answers are the obvious ones: the first stamp
        // after reset or a clear records nothing, a clear reads all zero, a lone
        // busy interval is 100 percent and an idle one is 0 percent.
        directed_rows = '{
            // first stamp after reset, top of the time range
            '{CMD_RECORD, 31'h7FFF_FFFF, 1'b1, 1'b1, '{7'd0, 7'd0, 1'b0}},
            // same stamp again: zero interval is raised to one microsecond
            '{CMD_RECORD, 31'h7FFF_FFFF, 1'b1, 1'b1, '{7'd100, 7'd100, 1'b0}},
            // time wraps past 2^31 back to zero
            '{CMD_RECORD, 31'h0000_0000, 1'b0, 1'b0, '{7'd0, 7'd0, 1'b0}},
            '{CMD_RECORD, 31'h0000_0000, 1'b0, 1'b0, '{7'd0, 7'd0, 1'b0}},
            // interval exactly at the clamp
            '{CMD_RECORD, 31'h01FF_FFFF, 1'b1, 1'b0, '{7'd0, 7'd0, 1'b0}},
            // one past the clamp
            '{CMD_RECORD, 31'h03FF_FFFF, 1'b1, 1'b0, '{7'd0, 7'd0, 1'b0}},
            // huge gap, clamped
            '{CMD_RECORD, 31'h7FFF_FFFE, 1'b0, 1'b0, '{7'd0, 7'd0, 1'b0}},
            '{CMD_RECORD, 31'h0000_0001, 1'b1, 1'b0, '{7'd0, 7'd0, 1'b0}},
            // time steps backward by one: wraps to nearly 2^31, clamped
            '{CMD_RECORD, 31'h0000_0000, 1'b0, 1'b0, '{7'd0, 7'd0, 1'b0}},
            // clear ignores its stamp and busy flag
            '{CMD_CLEAR,  31'h7FFF_FFFF, 1'b1, 1'b1, '{7'd0, 7'd0, 1'b0}},
            // clear while no stamp is held
            '{CMD_CLEAR,  31'h0000_0000, 1'b0, 1'b1, '{7'd0, 7'd0, 1'b0}},
            // first stamp after a clear
            '{CMD_RECORD, 31'h2AAA_AAAA, 1'b0, 1'b1, '{7'd0, 7'd0, 1'b0}},
            // one idle interval: nonzero total, zero busy
            '{CMD_RECORD, 31'h2AAA_AAB4, 1'b0, 1'b1, '{7'd0, 7'd0, 1'b0}},
            '{CMD_RECORD, 31'h5555_5555, 1'b1, 1'b0, '{7'd0, 7'd0, 1'b0}}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_beat(directed_rows[r].cmd, directed_rows[r].now, directed_rows[r].busy,
                      directed_rows[r].typed, directed_rows[r].want);
        end
        stamp_cursor = directed_rows[DIRECTED_N-1].now;

        // Random beats. Most are well-formed recordings with short, zero or
        // near-clamp gaps, so the windows fill, evict and wrap the report
        // counter; a few carry arbitrary stamps and a rare clear restarts it all.
        for (int n = 0; n < RANDOM_N; n++) begin
            calm_stretch = (n >= 150 && n < 230);
            pick = $urandom_range(0, 999);
            cmd = CMD_RECORD;
            if (pick < 3) begin
                cmd = CMD_CLEAR;
                now = brwm_pkg::STAMP_W'($urandom);
            end else if (pick < 20) begin
                now = brwm_pkg::STAMP_W'($urandom);
            end else begin
                if (pick < 60) begin
                    step = 0;
                end else if (pick < 100) begin
                    step = MAX_INTERVAL - 2 + $urandom_range(0, 4);
                end else begin
                    step = $urandom_range(1, 5000);
                end
                now = stamp_cursor + brwm_pkg::STAMP_W'(step);
            end
            stamp_cursor = now;
            send_beat(cmd, now, 1'($urandom), 1'b0, '0);
        end
        calm_stretch = 1'b0;
        i_valid <= 1'b0;

        // Drain: wait for every owed result, then give a stray one time to show up.
        while (expected_util_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
